// ===== src/ptrle_pkg.sv =====
// Package for the packed tile run-length decoder.
// Holds the input and result beat types and the fixed field widths.
// No dependencies.
package ptrle_pkg;

	// Fixed widths of the stream and of the result fields.
	localparam int BYTE_W  = 8;
	localparam int TILE_W  = 12;
	localparam int COUNT_W = 8;
	localparam int STORE_W = 20;
	localparam int HELD_W  = 5;
	// Arithmetic width for positions and counts; a board of up to 4096 tiles fits.
	localparam int CALC_W  = 13;

	// One beat of the packed tile stream.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              frame_start;
	} in_beat_t;

	// One run descriptor.
	typedef struct packed {
		logic [TILE_W-1:0]  start_position;
		logic [TILE_W-1:0]  first_tile;
		logic [TILE_W-1:0]  second_tile;
		logic [COUNT_W-1:0] repeat_count;
		logic               paired;
		logic               board_full;
	} out_beat_t;

endpackage

// ===== src/packed_tile_rle_decoder.sv =====
// Top level of the packed tile run-length decoder.
// Depends on ptrle_pkg for the beat types and field widths.
//
// Each byte is taken into an input register, and in the next cycle one pass of logic
// gathers it into 12- or 13-bit codes (least significant bit first), updates the run
// state and, when a tile completes a run, loads one run descriptor into the output
// register. One byte is accepted per cycle while the output register is not stalled.
// The output register is the only stall point: while a result waits there, the byte in
// the input register waits too and stalls the input. Runs are clipped to BOARD_TILES
// tiles; once the board is full, bytes are dropped until a beat with frame_start set.
// wide_codes selects 13-bit codes (reset value 1) and may be written only while the
// block is idle.
module packed_tile_rle_decoder #(
	parameter int BOARD_TILES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ptrle_pkg::in_beat_t  in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ptrle_pkg::out_beat_t out_beat
);
	import ptrle_pkg::*;

	localparam int POS_W = $clog2(BOARD_TILES + 1);
	localparam logic [CALC_W-1:0] BOARD_END = CALC_W'(BOARD_TILES);

	// Configuration register.
	logic wide_codes_q;

	// Input stage.
	logic     valid_s1;
	in_beat_t beat_s1;

	// Decoder state.
	logic [STORE_W-1:0] bit_store_q;
	logic [HELD_W-1:0]  bits_held_q;
	logic [COUNT_W-1:0] run_length_q;
	logic               pair_mode_q;
	logic [TILE_W-1:0]  held_tile_q;
	logic               held_valid_q;
	logic [POS_W-1:0]   board_pos_q;

	// Output register.
	logic      out_valid_q;
	out_beat_t out_q;

	// Next values from the decode pass.
	logic [STORE_W-1:0] bit_store_d;
	logic [HELD_W-1:0]  bits_held_d;
	logic [COUNT_W-1:0] run_length_d;
	logic               pair_mode_d;
	logic [TILE_W-1:0]  held_tile_d;
	logic               held_valid_d;
	logic [POS_W-1:0]   board_pos_d;
	logic               emit;
	out_beat_t          result;

	// Working values of the decode pass.
	logic [STORE_W-1:0] store_e;
	logic [HELD_W-1:0]  held_e;
	logic [COUNT_W-1:0] run_e;
	logic               pair_e;
	logic [TILE_W-1:0]  htile_e;
	logic               hvalid_e;
	logic [POS_W-1:0]   pos_e;
	logic [STORE_W-1:0] gathered;
	logic [HELD_W-1:0]  held_sum;
	logic [HELD_W-1:0]  code_w;
	logic [CALC_W-1:0]  code;
	logic               is_control;
	logic [TILE_W-1:0]  tile;
	logic [CALC_W-1:0]  pos_x;
	logic [CALC_W-1:0]  room;
	logic [CALC_W-1:0]  limit;
	logic [CALC_W-1:0]  run_x;
	logic [CALC_W-1:0]  n;
	logic [CALC_W-1:0]  pos_next_x;

	logic advance;

	// The input stage moves on whenever the output register can take a beat.
	assign advance   = ~out_valid_q | ~out_stall;
	assign in_stall  = valid_s1 & ~advance;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_codes_q <= 1'b1;
		end else if (cfg_wr_en) begin
			wide_codes_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_beat;
		end
	end

	// Decode pass: frame clear, bit gathering, code split and run bookkeeping.
	always_comb begin
		// A frame start clears the state before this byte is used.
		if (beat_s1.frame_start) begin
			store_e  = '0;
			held_e   = '0;
			run_e    = COUNT_W'(1);
			pair_e   = 1'b0;
			htile_e  = '0;
			hvalid_e = 1'b0;
			pos_e    = '0;
		end else begin
			store_e  = bit_store_q;
			held_e   = bits_held_q;
			run_e    = run_length_q;
			pair_e   = pair_mode_q;
			htile_e  = held_tile_q;
			hvalid_e = held_valid_q;
			pos_e    = board_pos_q;
		end

		gathered   = store_e | (STORE_W'(beat_s1.data_byte) << held_e);
		held_sum   = held_e + HELD_W'(BYTE_W);
		code_w     = wide_codes_q ? HELD_W'(13) : HELD_W'(12);
		code       = wide_codes_q ? gathered[CALC_W-1:0] : {1'b0, gathered[TILE_W-1:0]};
		is_control = wide_codes_q ? code[12] : code[11];
		tile       = code[TILE_W-1:0];
		pos_x      = CALC_W'(pos_e);
		room       = BOARD_END - pos_x;
		run_x      = CALC_W'(run_e);
		limit      = pair_e ? (room >> 1) : room;
		n          = (limit > run_x) ? run_x : limit;

		bit_store_d  = store_e;
		bits_held_d  = held_e;
		run_length_d = run_e;
		pair_mode_d  = pair_e;
		held_tile_d  = htile_e;
		held_valid_d = hvalid_e;
		pos_next_x   = pos_x;
		emit         = 1'b0;

		result.start_position = pos_x[TILE_W-1:0];
		result.first_tile     = tile;
		result.second_tile    = '0;
		result.repeat_count   = COUNT_W'(1);
		result.paired         = 1'b0;

		if (pos_x >= BOARD_END) begin
			// Board full: the byte is dropped.
		end else if (held_sum < code_w) begin
			bit_store_d = gathered;
			bits_held_d = held_sum;
		end else begin
			bit_store_d = gathered >> code_w;
			bits_held_d = held_sum - code_w;
			if (is_control) begin
				// Control code: load the count, maybe enter pair mode.
				if (code[8]) begin
					pair_mode_d = 1'b1;
				end
				run_length_d = code[COUNT_W-1:0];
			end else if (run_e == COUNT_W'(1)) begin
				// Single tile placed once.
				pos_next_x = pos_x + CALC_W'(1);
				emit       = 1'b1;
			end else if (pair_e && !hvalid_e) begin
				// First tile of a pair is held until its partner arrives.
				held_tile_d  = tile;
				held_valid_d = 1'b1;
			end else begin
				// Repeated single tile or repeated pair, clipped to the board.
				run_length_d = COUNT_W'(1);
				if (pair_e) begin
					held_valid_d = 1'b0;
					pair_mode_d  = 1'b0;
				end
				if (n != '0) begin
					emit                = 1'b1;
					result.repeat_count = n[COUNT_W-1:0];
					if (pair_e) begin
						pos_next_x         = pos_x + (n << 1);
						result.first_tile  = htile_e;
						result.second_tile = tile;
						result.paired      = 1'b1;
					end else begin
						pos_next_x = pos_x + n;
					end
				end
			end
		end

		board_pos_d       = pos_next_x[POS_W-1:0];
		result.board_full = (pos_next_x >= BOARD_END);
	end

	// Decoder state register, updated when the input stage moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_store_q  <= '0;
			bits_held_q  <= '0;
			run_length_q <= COUNT_W'(1);
			pair_mode_q  <= 1'b0;
			held_tile_q  <= '0;
			held_valid_q <= 1'b0;
			board_pos_q  <= '0;
		end else if (valid_s1 && advance) begin
			bit_store_q  <= bit_store_d;
			bits_held_q  <= bits_held_d;
			run_length_q <= run_length_d;
			pair_mode_q  <= pair_mode_d;
			held_tile_q  <= held_tile_d;
			held_valid_q <= held_valid_d;
			board_pos_q  <= board_pos_d;
		end
	end

	// Output register: holds a result until the far side takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= result;
		end
	end

endmodule

// ===== src/ptrle_checker.sv =====
// Port-level checks for the packed tile run-length decoder.
// Depends on ptrle_pkg; bound to packed_tile_rle_decoder at the end of this file.
module ptrle_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input ptrle_pkg::out_beat_t out_beat
);
	import ptrle_pkg::*;

	// A stalled result beat stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_beat))
		else $error("result payload changed while stalled");

	// Every run places at least one tile or pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_beat.repeat_count != '0)
		else $error("run with zero repeat");

	// A run that is not paired carries no second tile.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_beat.paired |-> out_beat.second_tile == '0)
		else $error("second tile set on a single run");

	// A fresh result follows an accepted input beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input beat");

endmodule

bind packed_tile_rle_decoder ptrle_checker u_ptrle_checker (.*);
